// ===== rtl/ktos_pkg.sv =====
package ktos_pkg;

  localparam int unsigned ENTRIES = 64;
  localparam int unsigned IDX_W   = $clog2(ENTRIES + 1);
  localparam int unsigned ADDR_W  = 24;
  localparam int unsigned TS_W    = 48;
  localparam int unsigned WIN_W   = 32;
  localparam int unsigned OCC_W   = 7;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned KIND_W  = 3;

  localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(ENTRIES - 1);
  localparam logic [OCC_W-1:0] ENTRIES_OCC = OCC_W'(ENTRIES);
  localparam logic [OCC_W-1:0] CAP_RESET   = OCC_W'(64);

  localparam logic CMD_OBSERVE = 1'b0;
  localparam logic CMD_SWEEP   = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_REFRESH = 3'd0,
    KIND_ADMIT   = 3'd1,
    KIND_EVICT   = 3'd2,
    KIND_STALE   = 3'd3,
    KIND_NONE    = 3'd4
  } kind_e;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
    logic [TS_W-1:0]   ts;
  } entry_t;

  typedef struct packed {
    logic   shift;
    entry_t wb;
  } ring_ctl_t;

endpackage

// ===== rtl/ktos_in_if.sv =====
interface ktos_in_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [ktos_pkg::ADDR_W-1:0]  aircraft_address;
  logic [ktos_pkg::TS_W-1:0]    timestamp_ms;
  logic [ktos_pkg::WIN_W-1:0]   stale_window;

  modport source (output valid, cmd, aircraft_address, timestamp_ms, stale_window,
                  input ready);
  modport sink   (input valid, cmd, aircraft_address, timestamp_ms, stale_window,
                  output ready);
endinterface

// ===== rtl/ktos_out_if.sv =====
interface ktos_out_if;
  logic                         valid;
  logic                         ready;
  logic [ktos_pkg::KIND_W-1:0]  kind;
  logic [ktos_pkg::ADDR_W-1:0]  reported_address;
  logic [ktos_pkg::OCC_W-1:0]   occupancy;
  logic [ktos_pkg::CNT_W-1:0]   eviction_total;
  logic                         last_of_run;

  modport source (output valid, kind, reported_address, occupancy, eviction_total,
                  last_of_run, input ready);
  modport sink   (input valid, kind, reported_address, occupancy, eviction_total,
                  last_of_run, output ready);
endinterface

// ===== rtl/ktos_cell.sv =====
module ktos_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_i,
  input  ktos_pkg::entry_t d_i,
  output ktos_pkg::entry_t q_o
);
  import ktos_pkg::*;

  logic                 valid_q;
  logic [ADDR_W-1:0]    addr_q;
  logic [TS_W-1:0]      ts_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= d_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      addr_q <= d_i.addr;
      ts_q   <= d_i.ts;
    end
  end

  assign q_o = '{valid: valid_q, addr: addr_q, ts: ts_q};

endmodule

// ===== rtl/ktos_ctrl.sv =====
module ktos_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [ktos_pkg::OCC_W-1:0] cfg_wdata_i,
  input  ktos_pkg::entry_t         head_i,
  output ktos_pkg::ring_ctl_t      ring_o,
  ktos_in_if.sink                  in_i,
  ktos_out_if.source               out_o
);
  import ktos_pkg::*;

  typedef enum logic [2:0] {ST_IDLE, ST_OBS1, ST_OBS2, ST_SWP, ST_EMIT} state_e;

  state_e             state_q, state_d, next_q, next_d;
  logic [IDX_W-1:0]   cnt_q, cnt_d;
  logic [OCC_W-1:0]   cap_q;
  logic [OCC_W-1:0]   vcnt_q, vcnt_d;
  logic [CNT_W-1:0]   evcnt_q, evcnt_d;
  logic [ADDR_W-1:0]  addr_q, addr_d;
  logic [TS_W-1:0]    now_q, now_d;
  logic [WIN_W-1:0]   win_q, win_d;
  logic               hit_q, hit_d;
  logic               best_v_q, best_v_d;
  logic [ADDR_W-1:0]  best_addr_q, best_addr_d;
  logic [TS_W-1:0]    best_ts_q, best_ts_d;
  logic               evict_q, evict_d;
  logic               done_q, done_d;
  logic               prev_v_q, prev_v_d;
  logic [ADDR_W-1:0]  prev_q, prev_d;
  logic               found_q, found_d;
  logic [ADDR_W-1:0]  min_q, min_d;
  kind_e              rkind_q, rkind_d;
  logic [ADDR_W-1:0]  raddr_q, raddr_d;
  logic               rlast_q, rlast_d;
  logic               ov_q, ov_d;
  kind_e              okind_q, okind_d;
  logic [ADDR_W-1:0]  oaddr_q, oaddr_d;
  logic [OCC_W-1:0]   oocc_q, oocc_d;
  logic [CNT_W-1:0]   oev_q, oev_d;
  logic               olast_q, olast_d;

  logic [OCC_W-1:0]   cap_eff;
  logic               pass_end;
  logic               stale;
  logic               older;
  logic [TS_W-1:0]    age;
  entry_t             wb;

  always_comb begin
    cap_eff = cap_q;
    if (cap_q == '0) cap_eff = OCC_W'(1);
    if (cap_q > ENTRIES_OCC) cap_eff = ENTRIES_OCC;
  end

  assign pass_end = (cnt_q == LAST_IDX);
  assign age      = now_q - head_i.ts;
  assign stale    = head_i.valid && (now_q > head_i.ts) && (age > TS_W'(win_q));
  assign older    = !best_v_q || (head_i.ts < best_ts_q) ||
                    ((head_i.ts == best_ts_q) && (head_i.addr < best_addr_q));

  always_comb begin
    state_d     = state_q;
    next_d      = next_q;
    cnt_d       = cnt_q;
    vcnt_d      = vcnt_q;
    evcnt_d     = evcnt_q;
    addr_d      = addr_q;
    now_d       = now_q;
    win_d       = win_q;
    hit_d       = hit_q;
    best_v_d    = best_v_q;
    best_addr_d = best_addr_q;
    best_ts_d   = best_ts_q;
    evict_d     = evict_q;
    done_d      = done_q;
    prev_v_d    = prev_v_q;
    prev_d      = prev_q;
    found_d     = found_q;
    min_d       = min_q;
    rkind_d     = rkind_q;
    raddr_d     = raddr_q;
    rlast_d     = rlast_q;
    ov_d        = ov_q;
    okind_d     = okind_q;
    oaddr_d     = oaddr_q;
    oocc_d      = oocc_q;
    oev_d       = oev_q;
    olast_d     = olast_q;
    wb          = head_i;

    if (ov_q && out_o.ready) ov_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          addr_d   = in_i.aircraft_address;
          now_d    = in_i.timestamp_ms;
          win_d    = in_i.stale_window;
          cnt_d    = '0;
          hit_d    = 1'b0;
          best_v_d = 1'b0;
          done_d   = 1'b0;
          prev_v_d = 1'b0;
          found_d  = 1'b0;
          state_d  = (in_i.cmd == CMD_SWEEP) ? ST_SWP : ST_OBS1;
        end
      end
      ST_OBS1: begin
        if (head_i.valid && head_i.addr == addr_q) begin
          wb.ts = now_q;
          hit_d = 1'b1;
        end else if (head_i.valid && older) begin
          best_v_d    = 1'b1;
          best_ts_d   = head_i.ts;
          best_addr_d = head_i.addr;
        end
        cnt_d = pass_end ? '0 : cnt_q + 1'b1;
        if (pass_end) begin
          if (hit_d) begin
            rkind_d = KIND_REFRESH;
            raddr_d = addr_q;
            rlast_d = 1'b1;
            next_d  = ST_IDLE;
            state_d = ST_EMIT;
          end else begin
            evict_d = (vcnt_q >= cap_eff);
            state_d = ST_OBS2;
          end
        end
      end
      ST_OBS2: begin
        if (!done_q && ((evict_q && head_i.valid && head_i.addr == best_addr_q) ||
                        (!evict_q && !head_i.valid))) begin
          wb     = '{valid: 1'b1, addr: addr_q, ts: now_q};
          done_d = 1'b1;
        end
        cnt_d = pass_end ? '0 : cnt_q + 1'b1;
        if (pass_end) begin
          rlast_d = 1'b1;
          next_d  = ST_IDLE;
          state_d = ST_EMIT;
          if (evict_q) begin
            rkind_d = KIND_EVICT;
            raddr_d = best_addr_q;
            if (evcnt_q != '1) evcnt_d = evcnt_q + 1'b1;
          end else begin
            rkind_d = KIND_ADMIT;
            raddr_d = addr_q;
            vcnt_d  = vcnt_q + 1'b1;
          end
        end
      end
      ST_SWP: begin
        if (prev_v_q && head_i.valid && head_i.addr == prev_q) begin
          wb.valid = 1'b0;
        end else if (stale && (!prev_v_q || head_i.addr > prev_q) &&
                     (!found_q || head_i.addr < min_q)) begin
          found_d = 1'b1;
          min_d   = head_i.addr;
        end
        cnt_d = pass_end ? '0 : cnt_q + 1'b1;
        if (pass_end) begin
          prev_v_d = 1'b1;
          prev_d   = min_d;
          if (!prev_v_q) begin
            if (!found_d) begin
              rkind_d = KIND_NONE;
              raddr_d = '0;
              rlast_d = 1'b1;
              next_d  = ST_IDLE;
              state_d = ST_EMIT;
            end
          end else begin
            vcnt_d  = vcnt_q - 1'b1;
            rkind_d = KIND_STALE;
            raddr_d = prev_q;
            rlast_d = !found_d;
            next_d  = rlast_d ? ST_IDLE : ST_SWP;
            state_d = ST_EMIT;
          end
          found_d = 1'b0;
        end
      end
      ST_EMIT: begin
        if (!ov_q || out_o.ready) begin
          ov_d    = 1'b1;
          okind_d = rkind_q;
          oaddr_d = raddr_q;
          oocc_d  = vcnt_q;
          oev_d   = evcnt_q;
          olast_d = rlast_q;
          state_d = next_q;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      next_q   <= ST_IDLE;
      cnt_q    <= '0;
      cap_q    <= CAP_RESET;
      vcnt_q   <= '0;
      evcnt_q  <= '0;
      ov_q     <= 1'b0;
      hit_q    <= 1'b0;
      best_v_q <= 1'b0;
      evict_q  <= 1'b0;
      done_q   <= 1'b0;
      prev_v_q <= 1'b0;
      found_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      next_q   <= next_d;
      cnt_q    <= cnt_d;
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      vcnt_q   <= vcnt_d;
      evcnt_q  <= evcnt_d;
      ov_q     <= ov_d;
      hit_q    <= hit_d;
      best_v_q <= best_v_d;
      evict_q  <= evict_d;
      done_q   <= done_d;
      prev_v_q <= prev_v_d;
      found_q  <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q      <= addr_d;
    now_q       <= now_d;
    win_q       <= win_d;
    best_addr_q <= best_addr_d;
    best_ts_q   <= best_ts_d;
    prev_q      <= prev_d;
    min_q       <= min_d;
    rkind_q     <= rkind_d;
    raddr_q     <= raddr_d;
    rlast_q     <= rlast_d;
    okind_q     <= okind_d;
    oaddr_q     <= oaddr_d;
    oocc_q      <= oocc_d;
    oev_q       <= oev_d;
    olast_q     <= olast_d;
  end

  assign ring_o.shift = (state_q == ST_OBS1) || (state_q == ST_OBS2) ||
                        (state_q == ST_SWP);
  assign ring_o.wb    = wb;

  assign in_i.ready             = (state_q == ST_IDLE);
  assign out_o.valid            = ov_q;
  assign out_o.kind             = okind_q;
  assign out_o.reported_address = oaddr_q;
  assign out_o.occupancy        = oocc_q;
  assign out_o.eviction_total   = oev_q;
  assign out_o.last_of_run      = olast_q;

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vcnt_q <= ENTRIES_OCC) else $error("occupancy above table size");
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && (okind_q == KIND_REFRESH || okind_q == KIND_ADMIT ||
              okind_q == KIND_EVICT || okind_q == KIND_NONE)) |-> olast_q)
    else $error("single-result transaction without last flag");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("ready after accept");
  a_evict_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> evcnt_q >= $past(evcnt_q))
    else $error("eviction count decreased");

endmodule

// ===== rtl/keyed_table_oldest_and_stale_evict.sv =====
// Address table of up to 64 entries held in a ring of cells that rotates one
// entry per cycle past a single controller during a pass, and holds still while
// idle or emitting. An observe transaction takes one full rotation to look for a
// hit and the oldest entry and to refresh a hit in place, and on a miss a second
// one to write the admit or replacement. A sweep transaction takes one rotation
// per removed address plus one, since each rotation finds the next stale address
// in ascending order. Input is taken only when the controller is idle; a finished
// result waits in the output register while the controller goes on.
module keyed_table_oldest_and_stale_evict (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [ktos_pkg::OCC_W-1:0] cfg_wdata_i,
  ktos_in_if.sink                    in_i,
  ktos_out_if.source                 out_o
);
  import ktos_pkg::*;

  entry_t    cell_q [ENTRIES];
  ring_ctl_t ring;

  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    entry_t d;
    if (k == ENTRIES - 1) begin : g_tail
      assign d = ring.wb;
    end else begin : g_mid
      assign d = cell_q[k+1];
    end
    ktos_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (ring.shift),
      .d_i     (d),
      .q_o     (cell_q[k])
    );
  end

  ktos_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .head_i      (cell_q[0]),
    .ring_o      (ring),
    .in_i        (in_i),
    .out_o       (out_o)
  );

endmodule
